FILE: sv/lgcs_pkg.sv
// types and constants shared by the gradient sampler modules
package lgcs_pkg;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_RECT_LEFT    = 3'd0;
    localparam logic [2:0] CFG_RECT_TOP     = 3'd1;
    localparam logic [2:0] CFG_RECT_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_RECT_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_AXIS_COS     = 3'd4;
    localparam logic [2:0] CFG_AXIS_SIN     = 3'd5;
    localparam logic [2:0] CFG_STOPS_IN_USE = 3'd6;

    localparam logic [16:0] T_ONE = 17'h10000;

    typedef struct packed {
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic signed [15:0] axis_cos;
        logic signed [15:0] axis_sin;
        logic [3:0]         stops_in_use;
    } t_cfg;

    typedef struct packed {
        logic               action;
        logic [2:0]         stop_slot;
        logic [16:0]        stop_place;
        logic [31:0]        stop_rgba;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [31:0] rem0;
        logic [15:0] low;
        logic [30:0] divisor;
        logic [4:0]  nbits;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

FILE: sv/lgcs_if.sv
// channel interfaces of the gradient sampler
interface lgcs_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [2:0]         stop_slot;
    logic [16:0]        stop_place;
    logic [31:0]        stop_rgba;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    modport source (output valid, action, stop_slot, stop_place, stop_rgba, point_x, point_y,
                    input ready);
    modport sink (input valid, action, stop_slot, stop_place, stop_rgba, point_x, point_y,
                  output ready);
endinterface

interface lgcs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_rgba;
    logic [16:0] axis_param;
    modport source (output valid, sample_rgba, axis_param, input ready);
    modport sink (input valid, sample_rgba, axis_param, output ready);
endinterface

interface lgcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lgcs_ram.sv
// generic single write port ram with registered read
module lgcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/lgcs_div.sv
// bit serial restoring divider, one quotient bit per cycle
module lgcs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lgcs_pkg::t_div_req i_req,
    output lgcs_pkg::t_div_rsp o_rsp
);
    import lgcs_pkg::*;

    logic [31:0] r_rem;
    logic [15:0] r_low;
    logic [15:0] r_q;
    logic [30:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_tr;
    logic        w_ge;

    assign w_tr = {r_rem[30:0], r_low[15]};
    assign w_ge = w_tr >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.nbits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_low <= i_req.low;
            r_div <= i_req.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_tr - {1'b0, r_div}) : w_tr;
            r_low <= {r_low[14:0], 1'b0};
            r_q   <= {r_q[14:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;
endmodule

FILE: sv/lgcs_front.sv
// front end: configuration registers, input acceptance and item queue
module lgcs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lgcs_in_if.sink         i_in,
    lgcs_cfg_if.sink        i_cfg,
    output lgcs_pkg::t_cfg  o_cfg,
    output logic            o_q_valid,
    output lgcs_pkg::t_item o_q_item,
    input  logic            i_q_pop
);
    import lgcs_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cfg       r_cfg;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign i_cfg.ready = 1'b1;
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = i_q_pop && (r_cnt != 2'd0);

    always_comb begin
        w_item.action     = i_in.action;
        w_item.stop_slot  = i_in.stop_slot;
        w_item.stop_place = i_in.stop_place;
        w_item.stop_rgba  = i_in.stop_rgba;
        w_item.point_x    = i_in.point_x;
        w_item.point_y    = i_in.point_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_left    <= '0;
            r_cfg.rect_top     <= '0;
            r_cfg.rect_width   <= '0;
            r_cfg.rect_height  <= '0;
            r_cfg.axis_cos     <= 16'sd16384;
            r_cfg.axis_sin     <= '0;
            r_cfg.stops_in_use <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_RECT_LEFT:    r_cfg.rect_left    <= i_cfg.data;
                CFG_RECT_TOP:     r_cfg.rect_top     <= i_cfg.data;
                CFG_RECT_WIDTH:   r_cfg.rect_width   <= i_cfg.data[14:0];
                CFG_RECT_HEIGHT:  r_cfg.rect_height  <= i_cfg.data[14:0];
                CFG_AXIS_COS:     r_cfg.axis_cos     <= i_cfg.data;
                CFG_AXIS_SIN:     r_cfg.axis_sin     <= i_cfg.data;
                CFG_STOPS_IN_USE: r_cfg.stops_in_use <= i_cfg.data[3:0];
                default:          r_cfg.rect_left    <= r_cfg.rect_left;
            endcase
        end
    end

    assign o_cfg     = r_cfg;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
endmodule

FILE: sv/lgcs_back.sv
// back end: stop table, projection, stop search and colour interpolation
module lgcs_back #(
    parameter int MAX_STOPS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lgcs_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  lgcs_pkg::t_item i_q_item,
    output logic            o_q_pop,
    lgcs_out_if.source      o_res
);
    import lgcs_pkg::*;

    localparam int AW = $clog2(MAX_STOPS);
    localparam int NW = $clog2(MAX_STOPS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_M4   = 4'd5;
    localparam logic [3:0] S_T    = 4'd6;
    localparam logic [3:0] S_TW   = 4'd7;
    localparam logic [3:0] S_C0   = 4'd8;
    localparam logic [3:0] S_CHK0 = 4'd9;
    localparam logic [3:0] S_CHKL = 4'd10;
    localparam logic [3:0] S_SCAN = 4'd11;
    localparam logic [3:0] S_MIXM = 4'd12;
    localparam logic [3:0] S_MIXS = 4'd13;
    localparam logic [3:0] S_MIXW = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0]         r_state;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    logic signed [35:0] r_prod;
    logic signed [35:0] r_d;
    logic [30:0]        r_span;
    logic [16:0]        r_t;
    logic [AW-1:0]      r_idx;
    logic [16:0]        r_prev_pos;
    logic [31:0]        r_prev_col;
    logic [16:0]        r_num;
    logic [16:0]        r_den;
    logic [31:0]        r_ca;
    logic [31:0]        r_cb;
    logic [1:0]         r_ch;
    logic [31:0]        r_col;
    logic               r_ovalid;
    logic [31:0]        r_orgba;
    logic [16:0]        r_oparam;

    logic [NW-1:0]      w_n;
    logic [AW-1:0]      w_last;
    logic               w_we;
    logic [AW-1:0]      w_raddr;
    logic [48:0]        w_rdata;
    logic [16:0]        w_pos;
    logic [31:0]        w_col;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [17:0] w_ma;
    logic signed [17:0] w_mb;
    logic [35:0]        w_pabs;
    logic               w_dpos;
    logic               w_dge;
    logic               w_tstart;
    logic               w_rnd;
    logic [7:0]         w_a;
    logic [7:0]         w_b;
    logic signed [8:0]  w_diff;
    logic signed [28:0] w_y;
    logic [9:0]         w_v;
    t_div_req           w_req;
    t_div_rsp           w_rsp;

    always_comb begin
        if (32'(i_cfg.stops_in_use) > MAX_STOPS) begin
            w_n = NW'(MAX_STOPS);
        end else begin
            w_n = NW'(i_cfg.stops_in_use);
        end
    end
    assign w_last = AW'(32'(w_n) - 32'd1);

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_we    = o_q_pop && (i_q_item.action == ACT_LOAD)
                     && (32'(i_q_item.stop_slot) < MAX_STOPS);

    always_comb begin
        case (r_state)
            S_C0:    w_raddr = '0;
            S_CHK0:  w_raddr = w_last;
            S_CHKL:  w_raddr = AW'(1);
            S_SCAN:  w_raddr = r_idx + AW'(1);
            default: w_raddr = '0;
        endcase
    end

    lgcs_ram #(.WIDTH(49), .DEPTH(MAX_STOPS)) u_stops (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_q_item.stop_slot)),
        .i_wdata ({i_q_item.stop_place, i_q_item.stop_rgba}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_pos = w_rdata[48:32];
    assign w_col = w_rdata[31:0];

    assign w_dx   = $signed({r_px[15], r_px}) - $signed({i_cfg.rect_left[15], i_cfg.rect_left});
    assign w_dy   = $signed({r_py[15], r_py}) - $signed({i_cfg.rect_top[15], i_cfg.rect_top});
    assign w_a    = r_ca[{r_ch, 3'b000} +: 8];
    assign w_b    = r_cb[{r_ch, 3'b000} +: 8];
    assign w_diff = $signed({1'b0, w_b}) - $signed({1'b0, w_a});

    always_comb begin
        case (r_state)
            S_M0: begin
                w_ma = {w_dx[16], w_dx};
                w_mb = {{2{i_cfg.axis_cos[15]}}, i_cfg.axis_cos};
            end
            S_M1: begin
                w_ma = {w_dy[16], w_dy};
                w_mb = {{2{i_cfg.axis_sin[15]}}, i_cfg.axis_sin};
            end
            S_M2: begin
                w_ma = {3'b000, i_cfg.rect_width};
                w_mb = {{2{i_cfg.axis_cos[15]}}, i_cfg.axis_cos};
            end
            S_M3: begin
                w_ma = {3'b000, i_cfg.rect_height};
                w_mb = {{2{i_cfg.axis_sin[15]}}, i_cfg.axis_sin};
            end
            S_MIXM: begin
                w_ma = {{9{w_diff[8]}}, w_diff};
                w_mb = {1'b0, r_num};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    assign w_pabs   = r_prod[35] ? 36'(-r_prod) : 36'(r_prod);
    assign w_dpos   = !r_d[35] && (r_d != 36'sd0);
    assign w_dge    = r_d >= $signed({5'b00000, r_span});
    assign w_tstart = (r_state == S_T) && (r_span != 31'd0) && w_dpos && !w_dge;
    assign w_rnd    = (w_rsp.rem + {2'b00, r_span[30:1]}) >= {1'b0, r_span};

    assign w_y = $signed({3'b000, r_den, 9'b0}) + $signed({12'b0, r_den})
                 + $signed({r_prod[27:0], 1'b0});
    assign w_v = {2'b00, w_a} + {1'b0, w_rsp.quot[8:0]} - 10'd256;

    always_comb begin
        if (r_state == S_MIXS) begin
            w_req.start   = 1'b1;
            w_req.rem0    = {13'b0, w_y[27:9]};
            w_req.low     = {w_y[8:0], 7'b0};
            w_req.divisor = {13'b0, r_den, 1'b0};
            w_req.nbits   = 5'd9;
        end else begin
            w_req.start   = w_tstart;
            w_req.rem0    = {1'b0, r_d[30:0]};
            w_req.low     = '0;
            w_req.divisor = r_span;
            w_req.nbits   = 5'd16;
        end
    end

    lgcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_ovalid || o_res.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && (i_q_item.action == ACT_SAMPLE)) begin
                        r_state <= S_M0;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_M4;
                S_M4: r_state <= S_T;
                S_T: begin
                    r_state <= w_tstart ? S_TW : S_C0;
                end
                S_TW: begin
                    if (w_rsp.done) begin
                        r_state <= S_C0;
                    end
                end
                S_C0: begin
                    r_state <= (w_n == '0) ? S_OUT : S_CHK0;
                end
                S_CHK0: begin
                    r_state <= ((w_n == NW'(1)) || (r_t <= w_pos)) ? S_OUT : S_CHKL;
                end
                S_CHKL: begin
                    r_state <= (r_t >= w_pos) ? S_OUT : S_SCAN;
                end
                S_SCAN: begin
                    if ((r_prev_pos <= r_t) && (r_t <= w_pos)) begin
                        r_state <= (w_pos <= r_prev_pos) ? S_OUT : S_MIXM;
                    end else if (r_idx == w_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_MIXM: r_state <= S_MIXS;
                S_MIXS: r_state <= S_MIXW;
                S_MIXW: begin
                    if (w_rsp.done) begin
                        r_state <= (r_ch == 2'd0) ? S_OUT : S_MIXM;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px <= i_q_item.point_x;
                r_py <= i_q_item.point_y;
            end
            S_M1: r_d <= r_prod;
            S_M2: r_d <= r_d + r_prod;
            S_M3: begin
                if (r_prod[35]) begin
                    r_d <= r_d - r_prod;
                end
                r_span <= 31'(w_pabs);
            end
            S_M4: begin
                if (r_prod[35]) begin
                    r_d <= r_d - r_prod;
                end
                r_span <= r_span + 31'(w_pabs);
            end
            S_T: begin
                if ((r_span == 31'd0) || !w_dpos) begin
                    r_t <= '0;
                end else if (w_dge) begin
                    r_t <= T_ONE;
                end
            end
            S_TW: begin
                if (w_rsp.done) begin
                    r_t <= {1'b0, w_rsp.quot} + {16'b0, w_rnd};
                end
            end
            S_C0: begin
                if (w_n == '0) begin
                    r_col <= '0;
                end
            end
            S_CHK0: begin
                r_col      <= w_col;
                r_prev_pos <= w_pos;
                r_prev_col <= w_col;
            end
            S_CHKL: begin
                r_col <= w_col;
                r_idx <= AW'(1);
            end
            S_SCAN: begin
                if ((r_prev_pos <= r_t) && (r_t <= w_pos)) begin
                    r_col <= r_prev_col;
                    r_num <= r_t - r_prev_pos;
                    r_den <= w_pos - r_prev_pos;
                    r_ca  <= r_prev_col;
                    r_cb  <= w_col;
                    r_ch  <= 2'd3;
                end else begin
                    r_col      <= w_col;
                    r_prev_pos <= w_pos;
                    r_prev_col <= w_col;
                    r_idx      <= r_idx + AW'(1);
                end
            end
            S_MIXW: begin
                if (w_rsp.done) begin
                    r_col[{r_ch, 3'b000} +: 8] <= w_v[7:0];
                    r_ch <= r_ch - 2'd1;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    r_orgba  <= r_col;
                    r_oparam <= r_t;
                end
            end
            default: r_col <= r_col;
        endcase
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.sample_rgba = r_orgba;
    assign o_res.axis_param  = r_oparam;
endmodule

FILE: sv/linear_gradient_color_sampler_top.sv
// top level of the linear gradient colour sampler
//
// i_in carries load and sample transactions; a load writes one stop
// (position and premultiplied colour) into the stop table and gives no
// result, a sample gives one transaction on o_res with the colour and t.
// i_cfg writes the rectangle, axis and stop count registers; it is always
// ready. The user must see that it is written only while no transaction
// is in flight; the block itself does not enforce this. A two-entry
// queue sits between input acceptance and the sample engine, so inputs
// keep being taken while a result waits on o_res. A load is popped by
// the engine and written into the stop table. A sample is popped, then
// projected on one shared multiplier, then divided by the 16 step serial
// divider when needed, then goes through a stop search reading the stop
// table one entry per cycle and, when it falls between two stops, a
// serial interpolation of the four colour channels through the same
// divider, and is then output.
// Reset clears the registers to their defaults and empties the queue;
// the stop table is undefined until loaded. When o_res stalls, the
// engine holds its finished result and stops, and the queue fills.
module linear_gradient_color_sampler_top #(
    parameter int MAX_STOPS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lgcs_in_if.sink     i_in,
    lgcs_cfg_if.sink    i_cfg,
    lgcs_out_if.source  o_res
);
    import lgcs_pkg::*;

    t_cfg  w_cfg;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    lgcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .o_cfg     (w_cfg),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    lgcs_back #(.MAX_STOPS(MAX_STOPS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_res     (o_res)
    );
endmodule
